FILE: rtl/core/ulkd_pkg.sv
package ulkd_pkg;

  localparam int MAX_LINE  = 20;
  localparam int WINDOW    = 8;
  localparam int KEY_COUNT = 13;
  localparam int KEY_MAXLEN = WINDOW + 1;
  localparam int KEY_BITS  = 8 * KEY_MAXLEN;

  localparam logic [7:0] LINE_END_RESET = 8'd10;
  localparam logic [2:0] LED_RESET      = 3'b111;

  // mask bit positions
  localparam int FAN_ON_BIT  = 1;
  localparam int FAN_OFF_BIT = 2;
  localparam int LED_ON_BIT  = 7;  // LED k on at LED_ON_BIT + 2k, off one above

  typedef logic [WINDOW-1:0][7:0]  window_t;
  typedef logic [KEY_COUNT-1:0]    key_mask_t;

  // Keyword text right-justified: byte j counts back from the last character.
  localparam logic [KEY_BITS-1:0] KEY_TEXT [KEY_COUNT] = '{
    KEY_BITS'("CHECK"),   KEY_BITS'("FanON"),    KEY_BITS'("FanOFF"),
    KEY_BITS'("OpenDOOR"), KEY_BITS'("CloseDOOR"), KEY_BITS'("OpenGATE"),
    KEY_BITS'("CloseGATE"), KEY_BITS'("Led1ON"),  KEY_BITS'("Led1OFF"),
    KEY_BITS'("Led2ON"),  KEY_BITS'("Led2OFF"),  KEY_BITS'("Led3ON"),
    KEY_BITS'("Led3OFF")
  };

  localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{
    4'd5, 4'd5, 4'd6, 4'd8, 4'd9, 4'd8, 4'd9, 4'd6, 4'd7, 4'd6, 4'd7, 4'd6, 4'd7
  };

  // Keywords ending at the newest byte, given the bytes before it.
  function automatic key_mask_t key_hits(input logic [7:0] b, input window_t win);
    key_mask_t hits;
    logic      hit;
    hits = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      hit = (KEY_TEXT[k][7:0] == b);
      for (int j = 1; j < KEY_MAXLEN; j++) begin
        if (4'(j) < KEY_LEN[k] && KEY_TEXT[k][8*j +: 8] != win[j-1]) begin
          hit = 1'b0;
        end
      end
      hits[k] = hit;
    end
    return hits;
  endfunction

endpackage

FILE: rtl/core/uart_line_keyword_decoder_unit.sv
// Command line keyword decoder for bytes received over a serial link.
// Input stream s_axis_*: one received byte per transfer in tdata[7:0].
// Output stream m_axis_*: one result per closed line, tdata bits from low:
//   command_mask[12:0], fan_level, led_levels[2:0], zero padding to 24 bits.
// A line closes on the line-end byte or on any byte arriving with 20 bytes
// held; the closing byte is dropped. Mask bits tell which keywords appeared
// (matching stops at a zero byte). Fan and LED levels are updated, OFF wins.
// cfg_wr_en/cfg_wr_data set the line-end byte; write only while idle.
// The result follows the closing byte through the input register, then the
// result register. Throughput: one byte per cycle unless a closing byte stalls;
// the keyword compare against an 8-byte history window is combinational.
// Reset: line-end byte 10, empty line, fan off, LEDs dark (all ones).
// When the receiver stalls with a result pending, non-closing bytes keep
// flowing; a second closing byte waits in the input register and tready
// drops until the pending result is taken.
module uart_line_keyword_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // line_end_char
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // command_mask[12:0], fan_level, led_levels[2:0]
);

  logic [7:0]         line_end_char;
  logic               in_v;
  logic [7:0]         in_byte;
  ulkd_pkg::window_t  recent;
  logic [4:0]         line_count;
  logic               saw_zero;
  ulkd_pkg::key_mask_t match_flags;
  logic               fan_state;
  logic [2:0]         led_state;
  logic               out_v;
  logic [16:0]        out_data;

  logic               close;
  logic               stall;
  logic               advance;
  logic               fan_next;
  logic [2:0]         led_next;
  ulkd_pkg::key_mask_t hits;

  assign close = in_v && (in_byte == line_end_char ||
                          line_count >= 5'(ulkd_pkg::MAX_LINE));
  assign stall = close && out_v && !m_axis_tready;
  assign advance = in_v && !stall;
  assign s_axis_tready = !in_v || !stall;

  assign hits = ulkd_pkg::key_hits(in_byte, recent);

  always_comb begin
    fan_next = fan_state;
    if (match_flags[ulkd_pkg::FAN_ON_BIT])  fan_next = 1'b1;
    if (match_flags[ulkd_pkg::FAN_OFF_BIT]) fan_next = 1'b0;
    led_next = led_state;
    for (int k = 0; k < 3; k++) begin
      if (match_flags[ulkd_pkg::LED_ON_BIT + 2*k])     led_next[k] = 1'b0;
      if (match_flags[ulkd_pkg::LED_ON_BIT + 2*k + 1]) led_next[k] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_end_char <= ulkd_pkg::LINE_END_RESET;
    end else if (cfg_wr_en) begin
      line_end_char <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tready) begin
      in_v <= s_axis_tvalid;
    end
    if (s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      recent      <= '0;
      line_count  <= '0;
      saw_zero    <= 1'b0;
      match_flags <= '0;
      fan_state   <= 1'b0;
      led_state   <= ulkd_pkg::LED_RESET;
    end else if (advance) begin
      if (close) begin
        recent      <= '0;
        line_count  <= '0;
        saw_zero    <= 1'b0;
        match_flags <= '0;
        fan_state   <= fan_next;
        led_state   <= led_next;
      end else begin
        if (!saw_zero) begin
          if (in_byte == 8'd0) begin
            saw_zero <= 1'b1;
          end else begin
            match_flags <= match_flags | hits;
          end
        end
        recent     <= {recent[ulkd_pkg::WINDOW-2:0], in_byte};
        line_count <= line_count + 5'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance && close) begin
      out_v <= 1'b1;
    end else if (m_axis_tready) begin
      out_v <= 1'b0;
    end
    if (advance && close) begin
      out_data <= {led_next, fan_next, match_flags};
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {7'd0, out_data};

endmodule
